[sv/hmbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP message byte parser package
// Character codes, field kinds, status codes and the result record.
// ----------------------------------------------------------------------------
package hmbp_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [3:0] K_DELIM   = 4'd0;
  localparam logic [3:0] K_METHOD  = 4'd1;
  localparam logic [3:0] K_URI     = 4'd2;
  localparam logic [3:0] K_VERSION = 4'd3;
  localparam logic [3:0] K_CODE    = 4'd4;
  localparam logic [3:0] K_REASON  = 4'd5;
  localparam logic [3:0] K_NAME    = 4'd6;
  localparam logic [3:0] K_VALUE   = 4'd7;
  localparam logic [3:0] K_BODY    = 4'd8;

  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_OK         = 3'd1;
  localparam logic [2:0] ST_BAD_METHOD = 3'd2;
  localparam logic [2:0] ST_BAD_CODE   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE = 3'd5;
  localparam logic [2:0] ST_LINE_ONLY  = 3'd6;

  // The accumulator saturates at this value, one above the largest code.
  localparam logic [16:0] CODE_SAT = 17'h10000;

  typedef struct packed {
    logic [2:0]  status;
    logic        code_valid;
    logic [15:0] code_value;
    logic        header_pair_done;
    logic        field_start;
    logic [3:0]  field_kind;
    logic [7:0]  byte_out;
  } result_t;

endpackage
`default_nettype wire

[sv/http_message_byte_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP message byte parser
// Classifies each message byte as part of the start line, a header or body.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle with no bubbles while s_tready is high:
// the parse state, error flag and status code accumulator are updated in the
// same cycle as the byte is accepted. Its result is registered in the result
// register, or in the skid register behind it while the output stalls; the
// skid register keeps s_tready registered, so a stall on the output side
// holds the input back once it is full. There is no clearing pass after reset.
// message_kind must only be written while no message is in progress.
module http_message_byte_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,   // message_kind
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [7:0]                  s_tdata,       // [7:0] byte_in
  input  wire logic                        s_tlast,       // last_byte
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  // [7:0] byte_out, [8] field_start, [9] header_pair_done,
  // [25:10] code_value, [26] code_valid, [29:27] status, [31:30] zero
  output      logic [31:0]                 m_tdata,
  output      logic [3:0]                  m_tuser        // [3:0] field_kind
);
  import hmbp_pkg::*;

  typedef enum logic [4:0] {
    S_START, S_RQ_METHOD, S_RQ_METHOD_GAP, S_RQ_URI, S_RQ_URI_GAP,
    S_RQ_VERSION, S_RQ_EOL, S_RS_VERSION, S_RS_VERSION_GAP, S_RS_CODE,
    S_RS_CODE_GAP, S_RS_REASON, S_RS_EOL, S_HD_LINE, S_HD_NAME, S_HD_GAP,
    S_HD_VALUE, S_HD_EOL, S_BD_SEP, S_BD_FIRST, S_BD_DATA
  } state_t;

  logic        message_kind;
  state_t      state, state_next;
  logic [16:0] acc, acc_next;
  logic        err_seen, err_seen_next;
  result_t     res, out_reg, skid;
  logic        skid_valid;

  logic [7:0]  b;
  logic        in_acc;
  logic        is_space, is_lf, is_eol, is_colon, is_letter, is_digit;
  logic [7:0]  b_upper, b_lower;
  logic [20:0] acc_x10;
  logic [16:0] acc_sat;

  assign b         = s_tdata[7:0];
  assign in_acc    = s_tvalid && s_tready;
  assign is_space  = (b == CH_SPACE);
  assign is_lf     = (b == CH_LF);
  assign is_eol    = (b == CH_LF) || (b == CH_CR);
  assign is_colon  = (b == CH_COLON);
  assign is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
  assign b_upper   = (b >= 8'h61) ? (b - 8'h20) : b;
  assign b_lower   = ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;

  // Code times ten plus the new digit; the code is at most 65536 here.
  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {17'b0, b[3:0]};
  assign acc_sat = (acc_x10 > {4'b0, CODE_SAT}) ? CODE_SAT : acc_x10[16:0];

  always_comb begin
    logic [2:0] err;
    logic [2:0] endcode;
    err           = ST_BUSY;
    endcode       = ST_INCOMPLETE;
    state_next    = state;
    acc_next      = acc;
    err_seen_next = err_seen;
    res           = '0;
    res.byte_out  = b;
    res.field_kind = K_DELIM;

    unique case (state)
      S_START: begin
        if (!is_space) begin
          if (message_kind) begin
            state_next = S_RS_VERSION;
            res.field_kind = K_VERSION;
            res.field_start = 1'b1;
          end else if (is_letter) begin
            state_next = S_RQ_METHOD;
            res.byte_out = b_upper;
            res.field_kind = K_METHOD;
            res.field_start = 1'b1;
          end else begin
            err = ST_BAD_METHOD;
          end
        end
      end
      S_RQ_METHOD: begin
        if (is_space) state_next = S_RQ_METHOD_GAP;
        else if (is_letter) begin
          res.byte_out = b_upper;
          res.field_kind = K_METHOD;
        end else err = ST_BAD_METHOD;
      end
      S_RQ_METHOD_GAP: begin
        if (!is_space) begin
          state_next = S_RQ_URI;
          res.field_kind = K_URI;
          res.field_start = 1'b1;
        end
      end
      S_RQ_URI: begin
        if (is_space) state_next = S_RQ_URI_GAP;
        else res.field_kind = K_URI;
      end
      S_RQ_URI_GAP: begin
        if (is_eol) begin
          state_next = is_lf ? S_HD_LINE : S_RQ_EOL;
          if (is_lf) endcode = ST_LINE_ONLY;
        end else if (!is_space) begin
          state_next = S_RQ_VERSION;
          res.field_kind = K_VERSION;
          res.field_start = 1'b1;
        end
      end
      S_RQ_VERSION: begin
        if (is_eol) begin
          state_next = is_lf ? S_HD_LINE : S_RQ_EOL;
          if (is_lf) endcode = ST_LINE_ONLY;
        end else res.field_kind = K_VERSION;
      end
      S_RQ_EOL, S_RS_EOL: begin
        if (is_lf) begin
          state_next = S_HD_LINE;
          endcode = ST_LINE_ONLY;
        end
      end
      S_RS_VERSION: begin
        if (is_space) state_next = S_RS_VERSION_GAP;
        else res.field_kind = K_VERSION;
      end
      S_RS_VERSION_GAP: begin
        if (!is_space) begin
          state_next = S_RS_CODE;
          if (is_digit) begin
            acc_next = {13'b0, b[3:0]};
            res.field_kind = K_CODE;
            res.field_start = 1'b1;
          end else err = ST_BAD_CODE;
        end
      end
      S_RS_CODE: begin
        if (is_space) begin
          if (acc[16]) err = ST_OVERFLOW;
          else begin
            res.code_valid = 1'b1;
            res.code_value = acc[15:0];
            state_next = S_RS_CODE_GAP;
          end
        end else if (is_digit) begin
          acc_next = acc_sat;
          res.field_kind = K_CODE;
        end else err = ST_BAD_CODE;
      end
      S_RS_CODE_GAP: begin
        if (is_eol) begin
          state_next = is_lf ? S_HD_LINE : S_RS_EOL;
          if (is_lf) endcode = ST_LINE_ONLY;
        end else if (!is_space) begin
          state_next = S_RS_REASON;
          res.field_kind = K_REASON;
          res.field_start = 1'b1;
        end
      end
      S_RS_REASON: begin
        if (is_eol) begin
          state_next = is_lf ? S_HD_LINE : S_RS_EOL;
          if (is_lf) endcode = ST_LINE_ONLY;
        end else res.field_kind = K_REASON;
      end
      S_HD_LINE: begin
        if (is_eol) begin
          state_next = is_lf ? S_BD_FIRST : S_BD_SEP;
          if (is_lf) endcode = ST_OK;
        end else if (is_colon) begin
          // An empty name: the colon opens the value gap straight away.
          state_next = S_HD_GAP;
        end else if (!is_space) begin
          state_next = S_HD_NAME;
          res.byte_out = b_lower;
          res.field_kind = K_NAME;
          res.field_start = 1'b1;
        end
      end
      S_HD_NAME: begin
        if (is_colon) state_next = S_HD_GAP;
        else begin
          res.byte_out = b_lower;
          res.field_kind = K_NAME;
        end
      end
      S_HD_GAP: begin
        if (is_eol) begin
          res.header_pair_done = 1'b1;
          state_next = is_lf ? S_HD_LINE : S_HD_EOL;
          if (is_lf) endcode = ST_OK;
        end else if (!is_space) begin
          state_next = S_HD_VALUE;
          res.field_kind = K_VALUE;
          res.field_start = 1'b1;
        end
      end
      S_HD_VALUE: begin
        if (is_eol) begin
          res.header_pair_done = 1'b1;
          state_next = is_lf ? S_HD_LINE : S_HD_EOL;
          if (is_lf) endcode = ST_OK;
        end else res.field_kind = K_VALUE;
      end
      S_HD_EOL: begin
        if (is_lf) begin
          state_next = S_HD_LINE;
          endcode = ST_OK;
        end
      end
      S_BD_SEP: begin
        if (is_lf) begin
          state_next = S_BD_FIRST;
          endcode = ST_OK;
        end
      end
      S_BD_FIRST: begin
        state_next = S_BD_DATA;
        res.field_kind = K_BODY;
        res.field_start = 1'b1;
        endcode = ST_OK;
      end
      S_BD_DATA: begin
        res.field_kind = K_BODY;
        endcode = ST_OK;
      end
      default: state_next = S_START;
    endcase

    if (err_seen) begin
      // After an error every byte passes through untagged until the last one.
      state_next = state;
      acc_next = acc;
      res = '0;
      res.byte_out = b;
    end else if (err != ST_BUSY) begin
      err_seen_next = 1'b1;
      res = '0;
      res.byte_out = b;
      res.status = err;
    end else if (s_tlast) begin
      res.status = endcode;
    end

    if (s_tlast) begin
      state_next = S_START;
      acc_next = '0;
      err_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_kind <= 1'b0;
      state <= S_START;
      acc <= '0;
      err_seen <= 1'b0;
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) message_kind <= cfg_wr_data;
      if (in_acc) begin
        state <= state_next;
        acc <= acc_next;
        err_seen <= err_seen_next;
      end
      if (!m_tvalid || m_tready) begin
        out_reg <= skid_valid ? skid : res;
        if (skid_valid) begin
          m_tvalid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid <= 1'b1;
        skid <= res;
      end
    end
  end

  assign s_tready = !skid_valid;
  assign m_tdata  = {2'b0, out_reg.status, out_reg.code_valid, out_reg.code_value,
                     out_reg.header_pair_done, out_reg.field_start, out_reg.byte_out};
  assign m_tuser  = out_reg.field_kind;

  // A result waiting in the skid register implies the result register is full.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds a result while the output is empty");

  // The parser is back at the start of a message after its last byte.
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tlast) |=> (state == S_START && !err_seen && acc == '0))
    else $error("parser did not restart after the last byte");

  // A closing code space is always a delimiter with no error on it.
  a_code_is_delim: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reg.code_valid) |->
      (out_reg.field_kind == K_DELIM &&
       (out_reg.status == ST_BUSY || out_reg.status == ST_INCOMPLETE)))
    else $error("code reported on a byte that is not a clean delimiter");

endmodule
`default_nettype wire
